// ===== hdl/drc_pkg.sv =====
package drc_pkg;

  localparam int CoordWidth  = 10;
  localparam int StepWidth   = 11;
  localparam int DecWidth    = 14;
  localparam int PhaseWidth  = 11;
  localparam int PixelWidth  = 12;
  localparam int RadWidth    = 20;
  localparam int RemWidth    = 12;
  localparam int SqrtSteps   = RadWidth / 2;
  localparam int SqrtCntWidth = 4;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef logic [CoordWidth-1:0] coord_t;
  typedef logic [StepWidth-1:0]  step_t;
  typedef logic signed [PixelWidth-1:0] pixel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start_load;
    logic       sq_load;
    logic       sqrt_step;
    logic       len_load;
    logic       adv_step;
    logic       emit;
    logic       fin;
    logic [2:0] k;
  } drc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic y_lt_x;
    logic out_free;
  } drc_stat_t;

endpackage

// ===== hdl/drc_in_if.sv =====
interface drc_in_if;
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  drc_pkg::coord_t        center_x;
  drc_pkg::coord_t        center_y;
  drc_pkg::coord_t        radius;
  logic                   dashed;

  modport source (output valid, cmd, center_x, center_y, radius, dashed, input ready);
  modport sink (input valid, cmd, center_x, center_y, radius, dashed, output ready);
endinterface

// ===== hdl/drc_out_if.sv =====
interface drc_out_if;
  logic              valid;
  logic              ready;
  drc_pkg::pixel_t   pixel_x;
  drc_pkg::pixel_t   pixel_y;
  logic              lit;
  logic              last_of_step;
  logic              finished;

  modport source (output valid, pixel_x, pixel_y, lit, last_of_step, finished, input ready);
  modport sink (input valid, pixel_x, pixel_y, lit, last_of_step, finished, output ready);
endinterface

// ===== hdl/drc_ctrl.sv =====
module drc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_cmd,
  output logic                in_ready,
  input  drc_pkg::drc_stat_t  stat,
  output drc_pkg::drc_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state, state_next;
  logic [2:0] k, k_next;
  logic [drc_pkg::SqrtCntWidth-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.k      = k;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == drc_pkg::CMD_START) begin
            cmd.start_load = 1'b1;
            state_next     = S_SQ;
          end else if (stat.y_lt_x) begin
            state_next = S_FIN;
          end else begin
            cmd.adv_step = 1'b1;
            k_next       = '0;
            state_next   = S_EMIT;
          end
        end
      end
      S_SQ: begin
        cmd.sq_load = 1'b1;
        cnt_next    = '0;
        state_next  = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == drc_pkg::SqrtCntWidth'(drc_pkg::SqrtSteps - 1)) begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        cmd.len_load = 1'b1;
        k_next       = '0;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          k_next   = k + 1'b1;
          if (k == 3'd7) begin
            state_next = S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/drc_datapath.sv =====
module drc_datapath #(
  parameter int unsigned MAX_RADIUS = 1023
) (
  input  logic                clk,
  input  logic                rst,
  drc_in_if.sink              items,
  drc_out_if.source           pixels,
  input  drc_pkg::drc_cmd_t   cmd,
  output drc_pkg::drc_stat_t  stat
);

  drc_pkg::coord_t origin_x, origin_y;
  drc_pkg::step_t  step_x, step_y;
  logic signed [drc_pkg::DecWidth-1:0] decision;
  logic [drc_pkg::PhaseWidth-1:0] dash_phase;
  logic [9:0] gap_limit, dash_period;
  logic dash_mode;
  logic lit_step;

  logic [drc_pkg::RadWidth-1:0] rad;
  logic [drc_pkg::RemWidth-1:0] rem;
  logic [9:0] root;

  logic out_valid;
  drc_pkg::pixel_t out_x, out_y;
  logic out_lit, out_last, out_fin;

  drc_pkg::coord_t r_sat;
  drc_pkg::step_t  x_new, y_new;
  logic signed [drc_pkg::DecWidth-1:0] dec_next;
  logic [drc_pkg::PhaseWidth-1:0] phase_inc;
  logic [2*drc_pkg::StepWidth-1:0] square;
  logic [drc_pkg::RemWidth+1:0] rem_sh, trial, diff;
  logic [11:0] len3;
  drc_pkg::step_t a_op, b_op;
  drc_pkg::pixel_t px, py;

  always_comb begin
    if (32'(items.radius) > 32'(MAX_RADIUS)) begin
      r_sat = MAX_RADIUS[drc_pkg::CoordWidth-1:0];
    end else begin
      r_sat = items.radius;
    end

    // The steps are two's complement: y reaches -1 on a radius 0 circle.
    x_new = step_x + 1'b1;
    if (decision < 0) begin
      y_new    = step_y;
      dec_next = decision + $signed({2'b00, x_new, 1'b1});
    end else begin
      y_new    = step_y - 1'b1;
      dec_next = decision + $signed({2'b00, x_new, 1'b0})
                 - $signed({{2{y_new[drc_pkg::StepWidth-1]}}, y_new, 1'b0}) + 14'sd1;
    end

    phase_inc = dash_phase + 1'b1;

    square = step_y * step_y;

    rem_sh = {rem, rad[drc_pkg::RadWidth-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    diff   = rem_sh - trial;

    len3 = {2'b00, root} + {1'b0, root, 1'b0};

    // The upper half of the octants swaps the roles of x and y.
    a_op = cmd.k[2] ? step_y : step_x;
    b_op = cmd.k[2] ? step_x : step_y;
    px = cmd.k[0] ? drc_pkg::pixel_t'({2'b00, origin_x} - {a_op[drc_pkg::StepWidth-1], a_op})
                  : drc_pkg::pixel_t'({2'b00, origin_x} + {a_op[drc_pkg::StepWidth-1], a_op});
    py = cmd.k[1] ? drc_pkg::pixel_t'({2'b00, origin_y} + {b_op[drc_pkg::StepWidth-1], b_op})
                  : drc_pkg::pixel_t'({2'b00, origin_y} - {b_op[drc_pkg::StepWidth-1], b_op});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      step_x      <= '0;
      step_y      <= '0;
      decision    <= '0;
      dash_phase  <= '0;
      gap_limit   <= '0;
      dash_period <= '0;
      dash_mode   <= 1'b0;
      lit_step    <= 1'b0;
    end else begin
      if (cmd.start_load) begin
        origin_x   <= items.center_x;
        origin_y   <= items.center_y;
        dash_mode  <= items.dashed;
        step_x     <= '0;
        step_y     <= {1'b0, r_sat};
        decision   <= drc_pkg::DecWidth'(1) - $signed({4'b0000, r_sat});
        dash_phase <= '0;
        lit_step   <= 1'b1;
      end
      if (cmd.adv_step) begin
        lit_step <= !dash_mode || (dash_phase == '0) || (dash_phase > {1'b0, gap_limit});
        step_x   <= x_new;
        step_y   <= y_new;
        decision <= dec_next;
        if (phase_inc == {1'b0, dash_period}) begin
          dash_phase <= '0;
        end else begin
          dash_phase <= phase_inc;
        end
      end
      if (cmd.len_load) begin
        gap_limit   <= {2'b00, root[9:2]};
        dash_period <= len3[11:2];
      end
    end
  end

  // Integer square root, one result bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      rad  <= square[drc_pkg::RadWidth:1];
      rem  <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= {rad[drc_pkg::RadWidth-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= diff[drc_pkg::RemWidth-1:0];
        root <= {root[8:0], 1'b1};
      end else begin
        rem  <= rem_sh[drc_pkg::RemWidth-1:0];
        root <= {root[8:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.fin) begin
      out_valid <= 1'b1;
    end else if (pixels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x    <= px;
      out_y    <= py;
      out_lit  <= lit_step;
      out_last <= (cmd.k == 3'd7);
      out_fin  <= 1'b0;
    end else if (cmd.fin) begin
      out_x    <= '0;
      out_y    <= '0;
      out_lit  <= 1'b0;
      out_last <= 1'b1;
      out_fin  <= 1'b1;
    end
  end

  assign stat.y_lt_x   = ($signed(step_y) < $signed(step_x));
  assign stat.out_free = !out_valid || pixels.ready;

  assign pixels.valid        = out_valid;
  assign pixels.pixel_x      = out_x;
  assign pixels.pixel_y      = out_y;
  assign pixels.lit          = out_lit;
  assign pixels.last_of_step = out_last;
  assign pixels.finished     = out_fin;

endmodule

// ===== hdl/dashed_circle_rasterizer.sv =====
// Advance transaction: 8 pixel transactions, the first registered from the emit state that follows
// acceptance; the next item is taken once all eight are issued, and each one waits while the output is not free.
// Start transaction: radius square, bit-serial square root, dash length load, 8 pixels.
// Advance on a finished circle: one pixel transaction, with finished set.
// Synchronous reset clears the circle state to a radius 0 circle at the origin.
module dashed_circle_rasterizer #(
  parameter int unsigned MAX_RADIUS = 1023
) (
  input  logic       clk,
  input  logic       rst,
  drc_in_if.sink     items,
  drc_out_if.source  pixels
);

  drc_pkg::drc_cmd_t  cmd;
  drc_pkg::drc_stat_t stat;

  drc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_cmd   (items.cmd),
    .in_ready (items.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  drc_datapath #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .pixels (pixels),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// ===== sim/dashed_circle_rasterizer_test.sv =====
module dashed_circle_rasterizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget = 320;
  localparam int PrintLimit = 40;

  typedef struct {
    drc_pkg::pixel_t px;
    drc_pkg::pixel_t py;
    logic            lit;
    logic            last;
    logic            fin;
  } pixel_exp_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_THIRDS, STALL_HEAVY} stall_mode_t;

  logic clk;
  logic rst;

  drc_in_if  items_if ();
  drc_out_if pixels_if ();

  dashed_circle_rasterizer i_dut (
    .clk    (clk),
    .rst    (rst),
    .items  (items_if),
    .pixels (pixels_if)
  );

  // Predicted circle state.
  drc_pkg::coord_t                       circ_ox;
  drc_pkg::coord_t                       circ_oy;
  logic signed [drc_pkg::StepWidth-1:0]  circ_x;
  logic signed [drc_pkg::StepWidth-1:0]  circ_y;
  logic signed [drc_pkg::DecWidth-1:0]   circ_dec;
  logic [drc_pkg::PhaseWidth-1:0]        dash_ph;
  logic [drc_pkg::CoordWidth-1:0]        dash_gap;
  logic [drc_pkg::CoordWidth-1:0]        dash_wrap;
  logic                                  dash_on;

  pixel_exp_t expected_pixels[$];
  int         fail_count = 0;
  int         sent_items = 0;
  int         burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= PrintLimit) begin
      $display("%0t: mismatch: %s", $realtime, what);
    end
  endtask

  function automatic int unsigned floor_sqrt(input int unsigned v);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = 1023;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  task automatic reset_circle();
    circ_ox   = '0;
    circ_oy   = '0;
    circ_x    = '0;
    circ_y    = '0;
    circ_dec  = '0;
    dash_ph   = '0;
    dash_gap  = '0;
    dash_wrap = '0;
    dash_on   = 1'b0;
  endtask

  // Queues the eight mirror images of the current point.
  task automatic push_octants(input logic lit);
    int ox;
    int oy;
    int x;
    int y;
    int px[8];
    int py[8];
    pixel_exp_t e;
    ox = circ_ox;
    oy = circ_oy;
    x  = circ_x;
    y  = circ_y;
    px = '{ox + x, ox - x, ox + x, ox - x, ox + y, ox - y, ox + y, ox - y};
    py = '{oy - y, oy - y, oy + y, oy + y, oy - x, oy - x, oy + x, oy + x};
    for (int k = 0; k < 8; k++) begin
      e.px   = drc_pkg::PixelWidth'(px[k]);
      e.py   = drc_pkg::PixelWidth'(py[k]);
      e.lit  = lit;
      e.last = (k == 7);
      e.fin  = 1'b0;
      expected_pixels.push_back(e);
    end
  endtask

  task automatic predict_pixels(input logic c, input drc_pkg::coord_t cx,
                                input drc_pkg::coord_t cy, input drc_pkg::coord_t rad,
                                input logic d);
    int unsigned sq;
    int unsigned len;
    logic        lit_now;
    pixel_exp_t  e;
    if (c == drc_pkg::CMD_START) begin
      circ_ox  = cx;
      circ_oy  = cy;
      dash_on  = d;
      circ_x   = '0;
      circ_y   = $signed({1'b0, rad});
      circ_dec = drc_pkg::DecWidth'(1 - int'(rad));
      sq       = rad;
      sq       = sq * sq / 2;
      len      = floor_sqrt(sq);
      dash_gap  = drc_pkg::CoordWidth'(len / 4);
      dash_wrap = drc_pkg::CoordWidth'((3 * len) / 4);
      dash_ph   = '0;
      push_octants(1'b1);
    end else if (circ_y < circ_x) begin
      e.px   = '0;
      e.py   = '0;
      e.lit  = 1'b0;
      e.last = 1'b1;
      e.fin  = 1'b1;
      expected_pixels.push_back(e);
    end else begin
      lit_now = !dash_on || (dash_ph == 0) || (dash_ph > dash_gap);
      circ_x = drc_pkg::StepWidth'(circ_x + 1);
      if (circ_dec < 0) begin
        circ_dec = drc_pkg::DecWidth'(circ_dec + 2 * circ_x + 1);
      end else begin
        circ_y   = drc_pkg::StepWidth'(circ_y - 1);
        circ_dec = drc_pkg::DecWidth'(circ_dec + 2 * circ_x - 2 * circ_y + 1);
      end
      push_octants(lit_now);
      // With a zero period the phase only wraps at the counter width.
      dash_ph = dash_ph + 1'b1;
      if (dash_ph == {1'b0, dash_wrap}) dash_ph = '0;
    end
  endtask

  task automatic send_item(input logic c, input drc_pkg::coord_t cx, input drc_pkg::coord_t cy,
                           input drc_pkg::coord_t rad, input logic d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        items_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    items_if.valid    <= 1'b1;
    items_if.cmd      <= c;
    items_if.center_x <= cx;
    items_if.center_y <= cy;
    items_if.radius   <= rad;
    items_if.dashed   <= d;
    do @(posedge clk); while (!items_if.ready);
    predict_pixels(c, cx, cy, rad, d);
    burst_left--;
    sent_items++;
  endtask

  task automatic send_start(input drc_pkg::coord_t cx, input drc_pkg::coord_t cy,
                            input drc_pkg::coord_t rad, input logic d);
    send_item(drc_pkg::CMD_START, cx, cy, rad, d);
  endtask

  // Fields other than the command are don't-care on an advance, so fill them at random.
  task automatic send_advance();
    send_item(drc_pkg::CMD_ADVANCE, drc_pkg::coord_t'($urandom), drc_pkg::coord_t'($urandom),
              drc_pkg::coord_t'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    items_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_advance_from_reset();
    // The reset state behaves as a radius 0 circle at the origin.
    repeat (3) send_advance();
    wait_drained();
  endtask

  task automatic test_extreme_circles();
    send_start(10'd0, 10'd0, 10'd0, 1'b0);
    repeat (2) send_advance();
    send_start(10'd1023, 10'd1023, 10'd1023, 1'b1);
    repeat (3) send_advance();
    send_start(10'd0, 10'd0, 10'd1023, 1'b0);
    repeat (2) send_advance();
    send_start(10'd1023, 10'd0, 10'd1, 1'b1);
    repeat (3) send_advance();
    wait_drained();
  endtask

  task automatic test_short_dash();
    // Radius 2 gives a dash period of zero, radius 3 a period of one.
    send_start(10'd0, 10'd1023, 10'd2, 1'b1);
    repeat (3) send_advance();
    send_start(10'd512, 10'd341, 10'd3, 1'b1);
    repeat (4) send_advance();
    wait_drained();
  endtask

  task automatic test_random_circles();
    int  kind;
    int  cap;
    int  n_adv;
    bit  paused;
    drc_pkg::coord_t rad;
    paused = 1'b0;
    while (sent_items < ItemTarget) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_item(1'($urandom), drc_pkg::coord_t'($urandom), drc_pkg::coord_t'($urandom),
                  drc_pkg::coord_t'($urandom), 1'($urandom));
      end else begin
        if (kind <= 6) begin
          rad = drc_pkg::coord_t'($urandom_range(0, 40));
          // Some circles are abandoned part way by a new start.
          cap = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 5) : 1000;
        end else begin
          rad = drc_pkg::coord_t'($urandom_range(41, 1023));
          cap = $urandom_range(1, 20);
        end
        send_start(drc_pkg::coord_t'($urandom), drc_pkg::coord_t'($urandom), rad,
                   1'($urandom));
        n_adv = 0;
        while (!(circ_y < circ_x) && n_adv < cap) begin
          send_advance();
          n_adv++;
        end
        if (circ_y < circ_x) repeat ($urandom_range(0, 2)) send_advance();
      end
      if (!paused && sent_items >= ItemTarget / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end
    wait_drained();
  endtask

  initial begin : receiver_stall
    stall_mode_t mode;
    int          left;
    int          cyc;
    mode = STALL_NONE;
    left = 0;
    cyc  = 0;
    pixels_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 200);
      end
      case (mode)
        STALL_NONE: begin
          pixels_if.ready <= 1'b1;
        end
        STALL_RANDOM: begin
          pixels_if.ready <= ($urandom_range(0, 3) != 0);
        end
        STALL_THIRDS: begin
          pixels_if.ready <= (cyc % 3 == 0);
        end
        default: begin
          pixels_if.ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
      cyc++;
      left--;
    end
  end

  initial begin : pixel_check
    pixel_exp_t want;
    forever begin
      @(posedge clk);
      if (!rst && pixels_if.valid && pixels_if.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel (%0d, %0d)",
                                    pixels_if.pixel_x, pixels_if.pixel_y));
        end else begin
          want = expected_pixels.pop_front();
          if (pixels_if.pixel_x !== want.px) begin
            report_mismatch($sformatf("pixel_x %0d, expected %0d", pixels_if.pixel_x, want.px));
          end
          if (pixels_if.pixel_y !== want.py) begin
            report_mismatch($sformatf("pixel_y %0d, expected %0d", pixels_if.pixel_y, want.py));
          end
          if (pixels_if.lit !== want.lit) begin
            report_mismatch($sformatf("lit %b, expected %b", pixels_if.lit, want.lit));
          end
          if (pixels_if.last_of_step !== want.last) begin
            report_mismatch($sformatf("last_of_step %b, expected %b",
                                      pixels_if.last_of_step, want.last));
          end
          if (pixels_if.finished !== want.fin) begin
            report_mismatch($sformatf("finished %b, expected %b",
                                      pixels_if.finished, want.fin));
          end
        end
      end
    end
  end

  initial begin
    rst               <= 1'b1;
    items_if.valid    <= 1'b0;
    items_if.cmd      <= drc_pkg::CMD_START;
    items_if.center_x <= '0;
    items_if.center_y <= '0;
    items_if.radius   <= '0;
    items_if.dashed   <= 1'b0;
    reset_circle();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_advance_from_reset();
    test_extreme_circles();
    test_short_dash();
    test_random_circles();

    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
